// ----- src/rmq_pkg.sv -----
// Shared types and constants for the rotation matrix to quaternion unit.
`default_nettype none
package rmq_pkg;
  localparam int DATA_W = 16;
  localparam int BR_W = 2;
  localparam int LANES = 3;
  localparam int NABS_W = DATA_W + 1;
  localparam int QB = DATA_W - 1;
  localparam logic [BR_W-1:0] BR_W0 = 2'd0;
  localparam logic [BR_W-1:0] BR_X = 2'd1;
  localparam logic [BR_W-1:0] BR_Y = 2'd2;
  localparam logic [BR_W-1:0] BR_Z = 2'd3;
  typedef logic signed [DATA_W-1:0] fix_t;
endpackage
`default_nettype wire

// ----- src/rmq_if.sv -----
// Valid/ready channel interfaces for matrix input and quaternion output.
`default_nettype none
interface rmq_in_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  fix_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  fix_t qw, qx, qy, qz;
  logic [BR_W-1:0] branch_used;
  logic degenerate;
  modport source(output valid, qw, qx, qy, qz, branch_used, degenerate, input ready);
  modport sink(input valid, qw, qx, qy, qz, branch_used, degenerate, output ready);
endinterface
`default_nettype wire

// ----- src/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module rmq_sqrt #(
  parameter int VW = 34,
  parameter int SBW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [VW-1:0]  in_v,
  input  wire logic [SBW-1:0] in_sb,
  output logic                out_valid,
  output logic [(VW+1)/2-1:0] out_root,
  output logic [SBW-1:0]      out_sb
);
  localparam int SW = (VW + 1) / 2;
  localparam int RMW = 2 * SW + 1;

  logic [SW-1:0]  vld_r;
  logic [RMW-1:0] rem_r  [SW];
  logic [SW-1:0]  root_r [SW];
  logic [SBW-1:0] sb_r   [SW];

  for (genvar gs = 0; gs < SW; gs++) begin : g_st
    localparam int K = SW - 1 - gs;
    logic           vld_in;
    logic [RMW-1:0] rem_in;
    logic [SW-1:0]  root_in;
    logic [SBW-1:0] sb_in;
    logic [RMW-1:0] trial;
    logic           take;

    if (gs == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = RMW'(in_v);
      assign root_in = '0;
      assign sb_in = in_sb;
    end else begin : g_next
      assign vld_in = vld_r[gs-1];
      assign rem_in = rem_r[gs-1];
      assign root_in = root_r[gs-1];
      assign sb_in = sb_r[gs-1];
    end

    assign trial = (RMW'(root_in) << (K + 1)) | (RMW'(1) << (2 * K));
    assign take = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[gs] <= 1'b0;
      end else if (en) begin
        vld_r[gs] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gs] <= take ? rem_in - trial : rem_in;
        root_r[gs] <= take ? (root_in | (SW'(1) << K)) : root_in;
        sb_r[gs] <= sb_in;
      end
    end
  end

  assign out_valid = vld_r[SW-1];
  assign out_root = root_r[SW-1];
  assign out_sb = sb_r[SW-1];
endmodule
`default_nettype wire

// ----- src/rmq_div.sv -----
// Three-lane pipelined restoring divider for the scaled off-diagonal terms.
`default_nettype none
module rmq_div #(
  parameter int FRAC_BITS = 14,
  parameter int SW = 17,
  parameter int SBW = 8
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          en,
  input  wire logic                                          in_valid,
  input  wire logic [rmq_pkg::LANES-1:0][rmq_pkg::NABS_W-1:0] in_mag,
  input  wire logic [SW-1:0]                                 in_root,
  input  wire logic [SBW-1:0]                                in_sb,
  output logic                                               out_valid,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::QB-1:0]         out_q,
  output logic [rmq_pkg::LANES-1:0]                          out_ovf,
  output logic [SBW-1:0]                                     out_sb
);
  import rmq_pkg::*;

  localparam int NUMW = ((NABS_W + FRAC_BITS > SW) ? NABS_W + FRAC_BITS : SW) + 1;
  localparam int WW = ((NUMW > SW + 1 + QB) ? NUMW : SW + 1 + QB) + 1;

  logic [QB:0]                      vld_r;
  logic [LANES-1:0][WW-1:0]         rem_r [QB+1];
  logic [LANES-1:0][QB-1:0]         q_r   [QB+1];
  logic [LANES-1:0]                 ovf_r [QB+1];
  logic [WW-1:0]                    d_r   [QB+1];
  logic [SBW-1:0]                   sb_r  [QB+1];

  logic [LANES-1:0][WW-1:0] num;
  logic [LANES-1:0]         ovf0;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num[l] = (WW'(in_mag[l]) << FRAC_BITS) + WW'(in_root);
      ovf0[l] = num[l] >= (WW'(in_root) << DATA_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      q_r[0] <= '0;
      ovf_r[0] <= ovf0;
      d_r[0] <= WW'(in_root) << 1;
      sb_r[0] <= in_sb;
    end
  end

  for (genvar gs = 1; gs <= QB; gs++) begin : g_st
    localparam int K = QB - gs;
    logic [WW-1:0]            dk;
    logic [LANES-1:0][WW-1:0] rem_nxt;
    logic [LANES-1:0][QB-1:0] q_nxt;

    assign dk = d_r[gs-1] << K;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_r[gs-1][l] >= dk) begin
          rem_nxt[l] = rem_r[gs-1][l] - dk;
          q_nxt[l] = q_r[gs-1][l] | (QB'(1) << K);
        end else begin
          rem_nxt[l] = rem_r[gs-1][l];
          q_nxt[l] = q_r[gs-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[gs] <= 1'b0;
      end else if (en) begin
        vld_r[gs] <= vld_r[gs-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gs] <= rem_nxt;
        q_r[gs] <= q_nxt;
        ovf_r[gs] <= ovf_r[gs-1];
        d_r[gs] <= d_r[gs-1];
        sb_r[gs] <= sb_r[gs-1];
      end
    end
  end

  assign out_valid = vld_r[QB];
  assign out_q = q_r[QB];
  assign out_ovf = ovf_r[QB];
  assign out_sb = sb_r[QB];
endmodule
`default_nettype wire

// ----- src/rotation_matrix_to_quaternion_unit.sv -----
// Rotation matrix to quaternion (Shepperd's method), fully pipelined.
// The root is SW = (FRAC_BITS + max(FRAC_BITS,17) + 3) / 2 bits wide; 17 at FRAC_BITS = 14.
// The square root takes one stage per root bit and the dividers one per quotient bit after an input stage.
// Throughput: one matrix per cycle; the whole pipe holds while the output beat waits.
// Reset clears every valid bit; data registers are not reset.
`default_nettype none
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = 14
) (
  input wire logic clk,
  input wire logic rst_n,
  rmq_in_if.sink   in_ch,
  rmq_out_if.source out_ch
);
  import rmq_pkg::*;

  localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int VW = RW - 1 + FRAC_BITS;
  localparam int SW = (VW + 1) / 2;
  localparam int SBA = BR_W + 1 + LANES + LANES * NABS_W;
  localparam int SBB = BR_W + 1 + LANES + QB;

  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Front stage: branch choice, radicand and the off-diagonal terms.
  logic signed [RW-1:0] e00, e11, e22, trace, rad, one_c;
  logic [BR_W-1:0] br;
  logic signed [NABS_W-1:0] n_wx, n_wy, n_wz, n_xy, n_xz, n_yz;
  logic signed [LANES-1:0][NABS_W-1:0] nsel;
  logic [LANES-1:0] neg_a;
  logic [LANES-1:0][NABS_W-1:0] mag_a;

  always_comb begin
    e00 = RW'(in_ch.m00);
    e11 = RW'(in_ch.m11);
    e22 = RW'(in_ch.m22);
    one_c = RW'(1) << FRAC_BITS;
    trace = e00 + e11 + e22;
    n_wx = NABS_W'(in_ch.m21) - NABS_W'(in_ch.m12);
    n_wy = NABS_W'(in_ch.m02) - NABS_W'(in_ch.m20);
    n_wz = NABS_W'(in_ch.m10) - NABS_W'(in_ch.m01);
    n_xy = NABS_W'(in_ch.m01) + NABS_W'(in_ch.m10);
    n_xz = NABS_W'(in_ch.m02) + NABS_W'(in_ch.m20);
    n_yz = NABS_W'(in_ch.m12) + NABS_W'(in_ch.m21);
    if (trace > 0) begin
      br = BR_W0;
    end else if (e00 > e11 && e00 > e22) begin
      br = BR_X;
    end else if (e11 > e22) begin
      br = BR_Y;
    end else begin
      br = BR_Z;
    end
    case (br)
      BR_W0: begin
        rad = one_c + trace;
        nsel = {n_wz, n_wy, n_wx};
      end
      BR_X: begin
        rad = one_c + e00 - e11 - e22;
        nsel = {n_xz, n_xy, n_wx};
      end
      BR_Y: begin
        rad = one_c + e11 - e00 - e22;
        nsel = {n_yz, n_xy, n_wy};
      end
      default: begin
        rad = one_c + e22 - e00 - e11;
        nsel = {n_yz, n_xz, n_wz};
      end
    endcase
    for (int l = 0; l < LANES; l++) begin
      neg_a[l] = nsel[l][NABS_W-1];
      mag_a[l] = neg_a[l] ? NABS_W'(-nsel[l]) : NABS_W'(nsel[l]);
    end
  end

  logic                         a_vld_r;
  logic [BR_W-1:0]              a_br_r;
  logic                         a_degen_r;
  logic [RW-2:0]                a_rad_r;
  logic [LANES-1:0]             a_neg_r;
  logic [LANES-1:0][NABS_W-1:0] a_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_br_r <= br;
      a_degen_r <= rad <= 0;
      a_rad_r <= rad[RW-2:0];
      a_neg_r <= neg_a;
      a_mag_r <= mag_a;
    end
  end

  logic [VW-1:0]  sq_v;
  logic           s_vld;
  logic [SW-1:0]  s_root;
  logic [SBA-1:0] s_sb;

  assign sq_v = a_degen_r ? '0 : {a_rad_r, {FRAC_BITS{1'b0}}};

  rmq_sqrt #(.VW(VW), .SBW(SBA)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(a_vld_r), .in_v(sq_v),
    .in_sb({a_br_r, a_degen_r, a_neg_r, a_mag_r}),
    .out_valid(s_vld), .out_root(s_root), .out_sb(s_sb)
  );

  logic [BR_W-1:0]              s_br;
  logic                         s_degen;
  logic [LANES-1:0]             s_neg;
  logic [LANES-1:0][NABS_W-1:0] s_mag;
  logic [SW:0]                  s_half;
  logic [QB-1:0]                s_half_sat;

  assign {s_br, s_degen, s_neg, s_mag} = s_sb;
  assign s_half = (SW+1)'(({1'b0, s_root} + (SW+1)'(1)) >> 1);
  assign s_half_sat = (s_half > (SW+1)'({QB{1'b1}})) ? {QB{1'b1}} : s_half[QB-1:0];

  logic                         d_vld;
  logic [LANES-1:0][QB-1:0]     d_q;
  logic [LANES-1:0]             d_ovf;
  logic [SBB-1:0]               d_sb;

  rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW), .SBW(SBB)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s_vld), .in_mag(s_mag), .in_root(s_root),
    .in_sb({s_br, s_degen || (s_root == '0), s_neg, s_half_sat}),
    .out_valid(d_vld), .out_q(d_q), .out_ovf(d_ovf), .out_sb(d_sb)
  );

  // Final stage: sign, saturation, zeroing when degenerate and placement of the components.
  logic [BR_W-1:0]  f_br;
  logic             f_degen;
  logic [LANES-1:0] f_neg;
  logic [QB-1:0]    f_half;
  fix_t             lane_v [LANES];
  fix_t             comp   [4];

  assign {f_br, f_degen, f_neg, f_half} = d_sb;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (d_ovf[l]) begin
        lane_v[l] = f_neg[l] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
      end else begin
        lane_v[l] = f_neg[l] ? -fix_t'({1'b0, d_q[l]}) : fix_t'({1'b0, d_q[l]});
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (f_degen) begin
        comp[c] = '0;
      end else if (BR_W'(c) == f_br) begin
        comp[c] = {1'b0, f_half};
      end else if (BR_W'(c) < f_br) begin
        comp[c] = lane_v[c];
      end else begin
        comp[c] = lane_v[c-1];
      end
    end
  end

  fix_t            qw_r, qx_r, qy_r, qz_r;
  logic [BR_W-1:0] br_out_r;
  logic            degen_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw_r <= comp[0];
      qx_r <= comp[1];
      qy_r <= comp[2];
      qz_r <= comp[3];
      br_out_r <= f_br;
      degen_out_r <= f_degen;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.qw = qw_r;
  assign out_ch.qx = qx_r;
  assign out_ch.qy = qy_r;
  assign out_ch.qz = qz_r;
  assign out_ch.branch_used = br_out_r;
  assign out_ch.degenerate = degen_out_r;
endmodule
`default_nettype wire
